[rtl/isu_pkg.sv]
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants of the Ising lattice site update block: lattice
// geometry, field widths, register indexes and the controller command word.
// ----------------------------------------------------------------------------
package isu_pkg;

    // lattice geometry, side must be a power of two
    localparam int SIDE   = 64;
    localparam int SIDE_W = $clog2(SIDE);
    localparam int SITES  = SIDE * SIDE;
    localparam int SITE_W = 2 * SIDE_W;

    // field widths
    localparam int SITE_FIELD_W = 12;
    localparam int DRAW_W       = 20;
    localparam int THR_W        = 20;
    localparam int DE_W         = 6;
    localparam int MAG_W        = 14;
    localparam int EN_W         = 15;
    localparam int CFG_IDX_W    = 1;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EIGHT = 1'b1;

    // reset values
    localparam logic [THR_W-1:0] THR_FOUR_RESET  = THR_W'(171690);
    localparam logic [THR_W-1:0] THR_EIGHT_RESET = THR_W'(29474);
    localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SITES);
    localparam logic signed [EN_W-1:0]  EN_RESET  = EN_W'(-2 * SITES);

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // neighbour read phases
    typedef enum logic [1:0] {
        PH_A = 2'd0,   // centre and left
        PH_B = 2'd1,   // right and up
        PH_C = 2'd2    // down
    } rd_phase_t;

    // controller to datapath commands
    typedef struct packed {
        logic      clear_step;
        logic      load;
        logic      rd_en;
        rd_phase_t phase;
        logic      cap_a;
        logic      cap_b;
        logic      commit;
    } isu_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_full;
    } isu_sts_t;

endpackage

[rtl/isu_ctrl.sv]
// ----------------------------------------------------------------------------
// isu_ctrl
// Sequencer of the site update: clearing pass after reset, word intake,
// three neighbour read phases and the commit step.
// ----------------------------------------------------------------------------
module isu_ctrl
    import isu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output isu_cmd_t cmd,
    input  isu_sts_t sts
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD_A  = 6'b000100,
        ST_RD_B  = 6'b001000,
        ST_RD_C  = 6'b010000,
        ST_EVAL  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.phase      = PH_A;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.phase  = PH_A;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_en  = 1'b1;
                cmd.phase  = PH_B;
                cmd.cap_a  = 1'b1;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.rd_en  = 1'b1;
                cmd.phase  = PH_C;
                cmd.cap_b  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!sts.out_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/isu_datapath.sv]
// ----------------------------------------------------------------------------
// isu_datapath
// Spin memory with two read ports and one write port, neighbour addressing,
// Metropolis decision, running totals, thresholds and the result register.
// ----------------------------------------------------------------------------
module isu_datapath
    import isu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  isu_cmd_t             cmd,
    output isu_sts_t             sts
);

    // spin memory, 1 = plus one
    logic mem [SITES];

    logic [SITE_W-1:0]       clr_cnt_reg;
    logic [THR_W-1:0]        thr_four_reg, thr_eight_reg;
    logic signed [MAG_W-1:0] mag_reg, mag_next;
    logic signed [EN_W-1:0]  en_reg, en_next;

    logic                    op_reg, val_reg;
    logic [SITE_FIELD_W-1:0] site_reg;
    logic [DRAW_W-1:0]       draw_reg;

    logic                    rd0_reg, rd1_reg;
    logic                    centre_reg, left_reg, right_reg, up_reg;

    logic                    out_valid_reg;
    logic                    flip_o_reg, spin_o_reg;
    logic signed [DE_W-1:0]  de_o_reg;
    logic signed [MAG_W-1:0] mag_o_reg;
    logic signed [EN_W-1:0]  en_o_reg;

    logic [SITE_W-1:0] site_addr, addr_l, addr_r, addr_u, addr_d;
    logic [SITE_W-1:0] ra0, ra1, wa;
    logic [SIDE_W-1:0] row, col;
    logic              we, wd;
    logic              in_range;
    logic [2:0]        plus_cnt;
    logic signed [DE_W-1:0] d_pos, d;
    logic              accept, change;

    // neighbour addresses, wrap is free for a power-of-two side
    assign site_addr = site_reg[SITE_W-1:0];
    assign row       = site_addr[SITE_W-1:SIDE_W];
    assign col       = site_addr[SIDE_W-1:0];
    assign addr_l    = {row, col - SIDE_W'(1)};
    assign addr_r    = {row, col + SIDE_W'(1)};
    assign addr_u    = {row - SIDE_W'(1), col};
    assign addr_d    = {row + SIDE_W'(1), col};
    assign in_range  = (32'(site_reg) < SITES);

    // read address selection
    always_comb
    begin
        unique case (cmd.phase)
            PH_A:
            begin
                ra0 = site_addr;
                ra1 = addr_l;
            end
            PH_B:
            begin
                ra0 = addr_r;
                ra1 = addr_u;
            end
            default:
            begin
                ra0 = addr_d;
                ra1 = addr_d;
            end
        endcase
    end

    // energy change of flipping the centre spin
    assign plus_cnt = 3'(left_reg) + 3'(right_reg) + 3'(up_reg) + 3'(rd0_reg);
    assign d_pos    = $signed({1'b0, plus_cnt, 2'b00}) - 6'sd8;
    assign d        = centre_reg ? d_pos : -d_pos;

    // acceptance test
    always_comb
    begin
        priority if (d <= 6'sd0)
        begin
            accept = 1'b1;
        end
        else if (d == 6'sd4)
        begin
            accept = (draw_reg <= thr_four_reg);
        end
        else
        begin
            accept = (draw_reg <= thr_eight_reg);
        end
    end

    assign change   = in_range && ((op_reg == OP_TRIAL) ? accept : (val_reg != centre_reg));
    assign mag_next = change ? (mag_reg + (centre_reg ? -14'sd2 : 14'sd2)) : mag_reg;
    assign en_next  = change ? (en_reg + EN_W'(d)) : en_reg;

    // memory write port
    assign we = cmd.clear_step || (cmd.commit && change);
    assign wa = cmd.clear_step ? clr_cnt_reg : site_addr;
    assign wd = cmd.clear_step ? 1'b1 : ~centre_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rd0_reg <= mem[ra0];
            rd1_reg <= mem[ra1];
        end
    end

    // captured word and neighbour spins
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser;
            site_reg <= s_tdata[SITE_FIELD_W-1:0];
            val_reg  <= s_tdata[SITE_FIELD_W];
            draw_reg <= s_tdata[SITE_FIELD_W+DRAW_W:SITE_FIELD_W+1];
        end
        if (cmd.cap_a)
        begin
            centre_reg <= rd0_reg;
            left_reg   <= rd1_reg;
        end
        if (cmd.cap_b)
        begin
            right_reg <= rd0_reg;
            up_reg    <= rd1_reg;
        end
    end

    // clearing counter, totals and thresholds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            mag_reg       <= MAG_RESET;
            en_reg        <= EN_RESET;
            thr_four_reg  <= THR_FOUR_RESET;
            thr_eight_reg <= THR_EIGHT_RESET;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SITE_W'(1);
            end
            if (cmd.commit)
            begin
                mag_reg <= mag_next;
                en_reg  <= en_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THR_FOUR:  thr_four_reg  <= cfg_data;
                    CFG_THR_EIGHT: thr_eight_reg <= cfg_data;
                    default:       thr_four_reg  <= thr_four_reg;
                endcase
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            flip_o_reg <= change && (op_reg == OP_TRIAL);
            spin_o_reg <= in_range && (centre_reg ^ change);
            de_o_reg   <= change ? d : 6'sd0;
            mag_o_reg  <= mag_next;
            en_o_reg   <= en_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, en_o_reg, mag_o_reg, de_o_reg, spin_o_reg, flip_o_reg};

    assign sts.clear_last = (clr_cnt_reg == SITE_W'(SITES - 1));
    assign sts.out_full   = out_valid_reg && !m_tready;

endmodule

[rtl/ising_metropolis_site_update.sv]
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis site update on a periodic square Ising lattice of one-bit spins.
// ----------------------------------------------------------------------------
// After reset the block sets every spin to plus one, site by site, and takes
// no word meanwhile; threshold writes are taken throughout. For each word the
// five spins of a site and its neighbours come out of a spin memory with two
// read ports over the read phases A, B and C, then the commit step decides,
// writes the spin back and loads the result register. A result waiting on the
// output does not stop the next word being accepted; it only holds the commit
// step.
module ising_metropolis_site_update
    import isu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [11:0] site, [12] spin_value, [32:13] random_draw, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] flipped, [1] spin_after, [7:2] energy_change, [21:8] magnetization,
    // [36:22] lattice_energy, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    isu_cmd_t cmd;
    isu_sts_t sts;

    // sequencer
    isu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // memory and arithmetic
    isu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[rtl/isu_checker.sv]
// ----------------------------------------------------------------------------
// isu_checker
// Port-level checks of the site update block, bound to the top level.
// ----------------------------------------------------------------------------
module isu_checker
    import isu_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous word still at work");

    // energy change is a flip of one spin against four neighbours
    a_de_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'h38) || (m_tdata[7:2] == 6'h3c) ||
                     (m_tdata[7:2] == 6'h00) || (m_tdata[7:2] == 6'h04) ||
                     (m_tdata[7:2] == 6'h08))
        else $error("energy change outside flip values");

    // totals keep their parity from the all-plus start
    a_totals_parity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8] == 1'b0) && (m_tdata[23:22] == 2'b00))
        else $error("running totals lost their parity");

endmodule

bind ising_metropolis_site_update isu_checker u_isu_checker (.*);
